// ===== sv/pssr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pssr_pkg: shared constants for the PID step-response scorer
// Fixed-point scale factors, limits and register indexes.
// ----------------------------------------------------------------------------
package pssr_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_SETPOINT    = 3'd3,
    CFG_SETTLE_BAND = 3'd4,
    CFG_TIMEOUT     = 3'd5,
    CFG_TURN_MODE   = 3'd6
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [15:0] SETPOINT_RST    = 16'd1440;
  localparam logic [14:0] SETTLE_BAND_RST = 15'd32;
  localparam logic [11:0] TIMEOUT_RST     = 12'd125;

  // Run control
  localparam logic [4:0]  HOLD_TICKS  = 5'd13;
  localparam logic [6:0]  DRIVE_LIMIT = 7'd52;
  localparam logic [11:0] TICK_MAX    = 12'hFFF;
  localparam logic [4:0]  BAND_MAX    = 5'd31;
  localparam logic [7:0]  OSC_MAX     = 8'd255;

  // Integral held in Q4 error units (the sample period is factored out of the
  // drive numerator), clamped to +-50 * 16 * 1000 / 20.
  localparam logic signed [17:0] INT_LIM = 18'sd40000;

  // Drive = N / 204800 with N = Kp*e*50 + Ki*I + Kd*de*2500 (20 ms sample).
  localparam logic signed [47:0] KP_SCALE  = 48'sd50;
  localparam logic signed [47:0] KD_SCALE  = 48'sd2500;
  localparam logic signed [47:0] DRV_LIM_N = 48'sd10649600; // 52 * 204800
  localparam int unsigned        DRV_SHIFT = 13;            // 204800 = 2^13 * 25
  localparam logic [10:0]        DIV25_RECIP = 11'd1311;    // 2^15 / 25, rounded up
  localparam int unsigned        DIV25_SHIFT = 15;

  // Seconds in Q4 = ticks * 8 / 25 = (ticks * 41944) >> 17
  localparam logic [15:0] SECS_RECIP = 16'd41944;
  localparam int unsigned SECS_SHIFT = 17;

  // Score weight of one sign change: 5.0 in Q4
  localparam logic [6:0]  OSC_WEIGHT = 7'd80;

endpackage

// ===== sv/pid_step_response_scorer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_step_response_scorer_unit: PID step with step-response scoring
// At most one PID update per sample word; reports drive, and at run end the score.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in_     | input     | valid / stall       | measurement, cancel, start_req
//  out_    | output    | valid / stall       | drives, run summary, score
//  cfg_    | input     | valid / ready       | 3-bit register index, 16-bit data
//
//  One word is taken per clock while in_stall is low. A word passes from
//  acceptance through the input register, run-state update, gain multipliers
//  and numerator sum to the output register; the constant divide by 25 sits
//  in front of the output register. The run state is updated as a word leaves
//  stage 1, so words follow each other with no gap.
//  rst_n is synchronous, active low; it clears the pipeline, the run state and
//  loads the configuration reset values. cfg_ready is always high.
//  A stall on the output backs up through the stages; empty stages are filled
//  first, so in_stall rises only once every stage holds a word.
// ----------------------------------------------------------------------------
module pid_step_response_scorer_unit (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_measurement,
  input  logic               in_cancel,
  input  logic               in_start_req,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [6:0]  out_left_drive,
  output logic signed [6:0]  out_right_drive,
  output logic               out_done_res,
  output logic               out_canceled,
  output logic [15:0]        out_final_error,
  output logic [15:0]        out_overshoot,
  output logic [7:0]         out_oscillations,
  output logic [11:0]        out_elapsed_ticks,
  output logic [23:0]        out_score,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0]        gain_p_r, gain_i_r, gain_d_r;
  logic signed [15:0] setpoint_r;
  logic [14:0]        settle_band_r;
  logic [11:0]        timeout_r;
  logic               turn_mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
      setpoint_r    <= pssr_pkg::SETPOINT_RST;
      settle_band_r <= pssr_pkg::SETTLE_BAND_RST;
      timeout_r     <= pssr_pkg::TIMEOUT_RST;
      turn_mode_r   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        pssr_pkg::CFG_GAIN_P:      gain_p_r      <= cfg_data;
        pssr_pkg::CFG_GAIN_I:      gain_i_r      <= cfg_data;
        pssr_pkg::CFG_GAIN_D:      gain_d_r      <= cfg_data;
        pssr_pkg::CFG_SETPOINT:    setpoint_r    <= cfg_data;
        pssr_pkg::CFG_SETTLE_BAND: settle_band_r <= cfg_data[14:0];
        pssr_pkg::CFG_TIMEOUT:     timeout_r     <= cfg_data[11:0];
        pssr_pkg::CFG_TURN_MODE:   turn_mode_r   <= cfg_data[0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its word moves on
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;
  logic out_ready, s4_ready, s3_ready, s2_ready, s1_ready;

  assign out_ready = !out_valid_r || !out_stall;
  assign s4_ready  = !s4_v_r || out_ready;
  assign s3_ready  = !s3_v_r || s4_ready;
  assign s2_ready  = !s2_v_r || s3_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_stall  = !s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready)  s1_v_r      <= in_valid;
      if (s2_ready)  s2_v_r      <= s1_v_r;
      if (s3_ready)  s3_v_r      <= s2_v_r;
      if (s4_ready)  s4_v_r      <= s3_v_r;
      if (out_ready) out_valid_r <= s4_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic signed [15:0] meas_r;
  logic               cancel_r, start_r;

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      meas_r   <= in_measurement;
      cancel_r <= in_cancel;
      start_r  <= in_start_req;
    end
  end

  // --------------------------------------------------------------------------
  // Run state, updated as a word leaves stage 1
  // --------------------------------------------------------------------------
  logic signed [16:0] integ_r, integ_nxt;   // integral, Q4 error units
  logic signed [16:0] last_err_r, last_err_nxt;
  logic               ls_nz_r, ls_nz_nxt;   // last nonzero error sign seen
  logic               ls_neg_r, ls_neg_nxt;
  logic [15:0]        max_past_r, max_past_nxt;
  logic [7:0]         osc_r, osc_nxt;
  logic [4:0]         band_r, band_nxt;
  logic [11:0]        tick_r, tick_nxt;
  logic               run_r, run_nxt;

  // Values toward stage 2
  logic               pid_c, done_c, canc_c;
  logic signed [16:0] e_c;
  logic signed [17:0] de_c;
  logic [15:0]        err_c;

  // Working signals
  logic signed [16:0] cur_integ, cur_le;
  logic               cur_lsnz, cur_lsneg, cur_run;
  logic [15:0]        cur_max;
  logic [7:0]         cur_osc;
  logic [4:0]         cur_band, band_inc;
  logic [11:0]        cur_tick;
  logic [16:0]        abs_e, abs_m, abs_sp;
  logic signed [17:0] past, isum;
  logic               e_nz;

  always_comb begin
    e_c    = 17'(signed'({setpoint_r[15], setpoint_r}) - signed'({meas_r[15], meas_r}));
    abs_e  = e_c[16] ? 17'(-e_c) : e_c;
    abs_m  = meas_r[15] ? 17'(-signed'({meas_r[15], meas_r})) : {1'b0, meas_r};
    abs_sp = setpoint_r[15] ? 17'(-signed'({setpoint_r[15], setpoint_r}))
                            : {1'b0, setpoint_r};
    err_c  = abs_e[15:0];
    e_nz   = (e_c != '0);
    past   = signed'({1'b0, abs_m}) - signed'({1'b0, abs_sp});

    // A start request clears the run and processes this word as its first
    cur_integ = start_r ? '0 : integ_r;
    cur_le    = start_r ? signed'({setpoint_r[15], setpoint_r}) : last_err_r;
    cur_lsnz  = start_r ? (setpoint_r != '0) : ls_nz_r;
    cur_lsneg = start_r ? setpoint_r[15] : ls_neg_r;
    cur_max   = start_r ? '0 : max_past_r;
    cur_osc   = start_r ? '0 : osc_r;
    cur_band  = start_r ? '0 : band_r;
    cur_tick  = start_r ? '0 : tick_r;
    cur_run   = start_r || run_r;

    isum     = signed'({cur_integ[16], cur_integ}) + signed'({e_c[16], e_c});
    de_c     = signed'({e_c[16], e_c}) - signed'({cur_le[16], cur_le});
    band_inc = (cur_band != pssr_pkg::BAND_MAX) ? cur_band + 5'd1 : cur_band;

    integ_nxt    = cur_integ;
    last_err_nxt = cur_le;
    ls_nz_nxt    = cur_lsnz;
    ls_neg_nxt   = cur_lsneg;
    max_past_nxt = cur_max;
    osc_nxt      = cur_osc;
    band_nxt     = cur_band;
    tick_nxt     = cur_tick;
    run_nxt      = cur_run;
    pid_c        = 1'b0;
    done_c       = 1'b0;
    canc_c       = 1'b0;

    if (cur_run) begin
      if (cancel_r) begin
        done_c = 1'b1;
        canc_c = 1'b1;
      end else if (cur_tick >= timeout_r) begin
        done_c = 1'b1;
      end else begin
        pid_c = 1'b1;
        if (isum > pssr_pkg::INT_LIM) begin
          integ_nxt = 17'(pssr_pkg::INT_LIM);
        end else if (isum < -pssr_pkg::INT_LIM) begin
          integ_nxt = 17'(-pssr_pkg::INT_LIM);
        end else begin
          integ_nxt = isum[16:0];
        end
        if (past > signed'({2'b00, cur_max})) begin
          max_past_nxt = past[15:0];
        end
        // Count a sign change only between two nonzero errors
        if (e_nz && cur_lsnz && (e_c[16] != cur_lsneg) && (cur_osc != pssr_pkg::OSC_MAX)) begin
          osc_nxt = cur_osc + 8'd1;
        end
        if (e_nz) begin
          ls_nz_nxt  = 1'b1;
          ls_neg_nxt = e_c[16];
        end
        if (cur_tick != pssr_pkg::TICK_MAX) begin
          tick_nxt = cur_tick + 12'd1;
        end
        if (abs_e < {2'b00, settle_band_r}) begin
          band_nxt = band_inc;
          if (band_inc >= pssr_pkg::HOLD_TICKS) begin
            done_c = 1'b1;
          end
        end else begin
          band_nxt = '0;
        end
        last_err_nxt = e_c;
      end
      if (done_c) begin
        run_nxt = 1'b0;
      end
    end
  end

  logic s1_adv;
  assign s1_adv = s1_v_r && s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      last_err_r <= '0;
      ls_nz_r    <= 1'b0;
      ls_neg_r   <= 1'b0;
      max_past_r <= '0;
      osc_r      <= '0;
      band_r     <= '0;
      tick_r     <= '0;
      run_r      <= 1'b0;
    end else if (s1_adv) begin
      integ_r    <= integ_nxt;
      last_err_r <= last_err_nxt;
      ls_nz_r    <= ls_nz_nxt;
      ls_neg_r   <= ls_neg_nxt;
      max_past_r <= max_past_nxt;
      osc_r      <= osc_nxt;
      band_r     <= band_nxt;
      tick_r     <= tick_nxt;
      run_r      <= run_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: PID operands and run summary (summary fields zero unless done)
  // --------------------------------------------------------------------------
  logic               s2_pid_r, s2_done_r, s2_canc_r;
  logic signed [16:0] s2_e_r, s2_integ_r;
  logic signed [17:0] s2_de_r;
  logic [15:0]        s2_err_r, s2_over_r;
  logic [7:0]         s2_osc_r;
  logic [11:0]        s2_tick_r;

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_pid_r   <= pid_c;
      s2_done_r  <= done_c;
      s2_canc_r  <= canc_c;
      s2_e_r     <= e_c;
      s2_integ_r <= integ_nxt;
      s2_de_r    <= de_c;
      s2_err_r   <= done_c ? err_c : '0;
      s2_over_r  <= done_c ? max_past_nxt : '0;
      s2_osc_r   <= done_c ? osc_nxt : '0;
      s2_tick_r  <= done_c ? tick_nxt : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: gain products, score base and seconds product
  // --------------------------------------------------------------------------
  logic               s3_pid_r, s3_done_r, s3_canc_r;
  logic signed [33:0] s3_pe_r, s3_pi_r;
  logic signed [34:0] s3_pd_r;
  logic [15:0]        s3_err_r, s3_over_r;
  logic [7:0]         s3_osc_r;
  logic [11:0]        s3_tick_r;
  logic [18:0]        s3_base_r;
  logic [27:0]        s3_secs_r;

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_pid_r  <= s2_pid_r;
      s3_done_r <= s2_done_r;
      s3_canc_r <= s2_canc_r;
      s3_pe_r   <= signed'({1'b0, gain_p_r}) * s2_e_r;
      s3_pi_r   <= signed'({1'b0, gain_i_r}) * s2_integ_r;
      s3_pd_r   <= signed'({1'b0, gain_d_r}) * s2_de_r;
      s3_err_r  <= s2_err_r;
      s3_over_r <= s2_over_r;
      s3_osc_r  <= s2_osc_r;
      s3_tick_r <= s2_tick_r;
      // 3*err + 2*over + 5.0*osc; peaks well below the 24-bit ceiling
      s3_base_r <= 19'({s2_err_r, 1'b0}) + 19'(s2_err_r) + 19'({s2_over_r, 1'b0})
                 + 19'(s2_osc_r) * 19'(pssr_pkg::OSC_WEIGHT);
      s3_secs_r <= s2_tick_r * pssr_pkg::SECS_RECIP;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: drive numerator, saturation flags and score
  // --------------------------------------------------------------------------
  logic signed [47:0] num_c;
  logic               s4_pid_r, s4_done_r, s4_canc_r;
  logic               s4_sat_pos_r, s4_sat_neg_r;
  logic signed [24:0] s4_num_r;
  logic [15:0]        s4_err_r, s4_over_r;
  logic [7:0]         s4_osc_r;
  logic [11:0]        s4_tick_r;
  logic [18:0]        s4_score_r;

  assign num_c = 48'(s3_pe_r) * pssr_pkg::KP_SCALE + 48'(s3_pi_r)
               + 48'(s3_pd_r) * pssr_pkg::KD_SCALE;

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_pid_r     <= s3_pid_r;
      s4_done_r    <= s3_done_r;
      s4_canc_r    <= s3_canc_r;
      s4_sat_pos_r <= (num_c >= pssr_pkg::DRV_LIM_N);
      s4_sat_neg_r <= (num_c <= -pssr_pkg::DRV_LIM_N);
      s4_num_r     <= num_c[24:0]; // holds the full value when not saturated
      s4_err_r     <= s3_err_r;
      s4_over_r    <= s3_over_r;
      s4_osc_r     <= s3_osc_r;
      s4_tick_r    <= s3_tick_r;
      s4_score_r   <= s3_base_r + 19'(s3_secs_r[27:pssr_pkg::SECS_SHIFT]);
    end
  end

  // --------------------------------------------------------------------------
  // Output register: truncate toward zero, saturate, apply turn mode
  // --------------------------------------------------------------------------
  logic [23:0]        num_mag;
  logic [10:0]        q_in;
  logic [21:0]        q_prod;
  logic [6:0]         drv_mag;
  logic signed [6:0]  drv_c, left_c;

  always_comb begin
    num_mag = s4_num_r[24] ? 24'(-s4_num_r) : s4_num_r[23:0];
    q_in    = num_mag[23:pssr_pkg::DRV_SHIFT];
    q_prod  = q_in * pssr_pkg::DIV25_RECIP;
    if (s4_sat_pos_r || s4_sat_neg_r) begin
      drv_mag = pssr_pkg::DRIVE_LIMIT;
    end else begin
      drv_mag = q_prod[21:pssr_pkg::DIV25_SHIFT];
    end
    if (!s4_pid_r) begin
      drv_c = '0;
    end else if (s4_sat_neg_r || (!s4_sat_pos_r && s4_num_r[24])) begin
      drv_c = 7'(-signed'(drv_mag));
    end else begin
      drv_c = drv_mag;
    end
    left_c = turn_mode_r ? 7'(-drv_c) : drv_c;
  end

  logic signed [6:0] left_r, right_r;
  logic              done_r, canc_r;
  logic [15:0]       err_r, over_r;
  logic [7:0]        osc_out_r;
  logic [11:0]       tick_out_r;
  logic [23:0]       score_r;

  always_ff @(posedge clk) begin
    if (out_ready) begin
      left_r     <= left_c;
      right_r    <= drv_c;
      done_r     <= s4_done_r;
      canc_r     <= s4_canc_r;
      err_r      <= s4_err_r;
      over_r     <= s4_over_r;
      osc_out_r  <= s4_osc_r;
      tick_out_r <= s4_tick_r;
      score_r    <= s4_done_r ? 24'(s4_score_r) : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_drive    = left_r;
  assign out_right_drive   = right_r;
  assign out_done_res      = done_r;
  assign out_canceled      = canc_r;
  assign out_final_error   = err_r;
  assign out_overshoot     = over_r;
  assign out_oscillations  = osc_out_r;
  assign out_elapsed_ticks = tick_out_r;
  assign out_score         = score_r;

endmodule
